/* hw/rtl/sv32ptw_pkg.sv */
// ----------------------------------------------------------------------------
// sv32ptw_pkg
// Shared types, codes and entry bit positions for the Sv32 page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package sv32ptw_pkg;

  localparam int unsigned VA_W    = 32;
  localparam int unsigned PA_W    = 34;
  localparam int unsigned PTE_W   = 32;
  localparam int unsigned PPN_W   = 22;
  localparam int unsigned ACC_W   = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CAUSE_W = 3;

  // entry flag bits
  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_R = 1;
  localparam int unsigned PTE_W_BIT = 2;
  localparam int unsigned PTE_X = 3;
  localparam int unsigned PTE_A = 6;
  localparam int unsigned PTE_D = 7;

  typedef enum logic [0:0] {
    OP_REQUEST = 1'b0,
    OP_ENTRY   = 1'b1
  } op_t;

  typedef enum logic [ACC_W-1:0] {
    ACC_READ  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_EXEC  = 2'd2
  } access_t;

  typedef enum logic [KIND_W-1:0] {
    RK_READ  = 2'd0,
    RK_DONE  = 2'd1,
    RK_FAULT = 2'd2
  } result_kind_t;

  typedef enum logic [CAUSE_W-1:0] {
    FC_NONE       = 3'd0,
    FC_INVALID    = 3'd1,
    FC_W_NO_R     = 3'd2,
    FC_NO_LEAF    = 3'd3,
    FC_PERMISSION = 3'd4,
    FC_MISALIGNED = 3'd5,
    FC_A_CLEAR    = 3'd6,
    FC_D_CLEAR    = 3'd7
  } fault_cause_t;

  typedef struct packed {
    logic               operation;
    logic [VA_W-1:0]    virtual_address;
    logic [ACC_W-1:0]   access_kind;
    logic [PTE_W-1:0]   table_entry;
  } item_t;

  typedef struct packed {
    logic               active;
    logic               level;
    logic [VA_W-1:0]    held_address;
    logic [ACC_W-1:0]   held_access;
  } walk_state_t;

  typedef struct packed {
    result_kind_t       kind;
    logic [PA_W-1:0]    address;
    fault_cause_t       cause;
    logic [PTE_W-1:0]   entry;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sv32ptw_ifs.sv */
// ----------------------------------------------------------------------------
// sv32ptw channel interfaces
// Valid/ready channels for requests and entries, results and the root page
// number write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sv32ptw_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] virtual_address;
  logic [1:0]  access_kind;
  logic [31:0] table_entry;

  modport source (output valid, output operation, output virtual_address,
                  output access_kind, output table_entry, input ready);
  modport sink   (input valid, input operation, input virtual_address,
                  input access_kind, input table_entry, output ready);
endinterface

interface sv32ptw_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [33:0] address;
  logic [2:0]  fault_cause;
  logic [31:0] fault_entry;

  modport source (output valid, output result_kind, output address,
                  output fault_cause, output fault_entry, input ready);
  modport sink   (input valid, input result_kind, input address,
                  input fault_cause, input fault_entry, output ready);
endinterface

interface sv32ptw_cfg_if;
  logic        valid;
  logic        ready;
  logic [21:0] root_page_number;

  modport source (output valid, output root_page_number, input ready);
  modport sink   (input valid, input root_page_number, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sv32ptw_step.sv */
// ----------------------------------------------------------------------------
// sv32ptw_step
// Walk logic for one word: entry checks, next read address or physical
// address, and the next walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module sv32ptw_step (
  input  sv32ptw_pkg::item_t       item,
  input  sv32ptw_pkg::walk_state_t st,
  input  logic [21:0]              root,
  output logic                     has_result,
  output sv32ptw_pkg::result_t     res,
  output sv32ptw_pkg::walk_state_t st_next
);
  import sv32ptw_pkg::*;

  logic [PTE_W-1:0] pte;
  logic             v, r, w, x, a, d;
  logic             permitted;
  logic             superpage;

  assign pte = item.table_entry;
  assign v   = pte[PTE_V];
  assign r   = pte[PTE_R];
  assign w   = pte[PTE_W_BIT];
  assign x   = pte[PTE_X];
  assign a   = pte[PTE_A];
  assign d   = pte[PTE_D];
  assign superpage = st.level;

  always_comb begin
    case (st.held_access)
      ACC_READ:  permitted = r;
      ACC_WRITE: permitted = w;
      ACC_EXEC:  permitted = x;
      default:   permitted = 1'b0;
    endcase
  end

  always_comb begin
    has_result = 1'b1;
    st_next    = st;
    res.kind    = RK_FAULT;
    res.address = '0;
    res.cause   = FC_NONE;
    res.entry   = '0;

    if (item.operation == OP_REQUEST) begin
      st_next.held_address = item.virtual_address;
      st_next.held_access  = item.access_kind;
      st_next.level        = 1'b1;
      st_next.active       = 1'b1;
      res.kind    = RK_READ;
      res.address = {root, item.virtual_address[31:22], 2'b00};
    end else if (!st.active) begin
      has_result = 1'b0;
    end else begin
      // any outcome other than a level-0 read ends the walk
      st_next.active = 1'b0;
      st_next.level  = 1'b1;
      res.entry      = pte;
      if (!v) begin
        res.cause = FC_INVALID;
      end else if (!r && w) begin
        res.cause = FC_W_NO_R;
      end else if (!r && !x) begin
        if (!st.level) begin
          res.cause = FC_NO_LEAF;
        end else begin
          st_next.active = 1'b1;
          st_next.level  = 1'b0;
          res.kind    = RK_READ;
          res.entry   = '0;
          res.address = {pte[31:10], st.held_address[21:12], 2'b00};
        end
      end else if (!permitted) begin
        res.cause = FC_PERMISSION;
      end else if (superpage && (pte[19:10] != '0)) begin
        res.cause = FC_MISALIGNED;
      end else if (!a) begin
        res.cause = FC_A_CLEAR;
      end else if ((st.held_access == ACC_WRITE) && !d) begin
        res.cause = FC_D_CLEAR;
      end else begin
        res.kind  = RK_DONE;
        res.entry = '0;
        if (superpage) begin
          res.address = {pte[31:20], st.held_address[21:0]};
        end else begin
          res.address = {pte[31:10], st.held_address[11:0]};
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sv32ptw_top.sv */
// ----------------------------------------------------------------------------
// sv32_page_table_walker_top
// Two-level Sv32 page table walker with valid/ready word channels.
// ----------------------------------------------------------------------------
// Usage: each word on req is a translation request (operation 0) or a table
// entry returned from memory (operation 1). A request always answers with a
// read of the level-1 entry; an entry answers with the level-0 read, a page
// fault with its cause and the entry word, or the 34-bit physical address.
// An entry that arrives with no walk active produces nothing, and a request
// during a walk restarts it. A and D bits are never updated: if A is clear,
// or D is clear on a write, the walker faults. One word is taken per cycle
// while no held result waits on rsp.ready; a word goes through the input
// register and the walk logic into the result register, and its result is
// then offered on rsp. Write root_page_number only while idle.
`default_nettype none

module sv32_page_table_walker_top (
  input  logic                 clk,
  input  logic                 rst,
  sv32ptw_cfg_if.sink          cfg,
  sv32ptw_req_if.sink          req,
  sv32ptw_rsp_if.source        rsp
);
  import sv32ptw_pkg::*;

  logic        in_valid;
  item_t       in_item;
  logic        adv;
  logic [21:0] root;
  walk_state_t st;
  walk_state_t st_next;
  logic        has_result;
  result_t     res;
  logic        out_valid;
  result_t     out_res;

  assign cfg.ready = 1'b1;
  assign adv       = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg.valid) begin
      root <= cfg.root_page_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.operation       <= req.operation;
      in_item.virtual_address <= req.virtual_address;
      in_item.access_kind     <= req.access_kind;
      in_item.table_entry     <= req.table_entry;
    end
  end

  sv32ptw_step u_step (
    .item       (in_item),
    .st         (st),
    .root       (root),
    .has_result (has_result),
    .res        (res),
    .st_next    (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.active       <= 1'b0;
      st.level        <= 1'b1;
      st.held_address <= '0;
      st.held_access  <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= has_result;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_res.kind;
  assign rsp.address     = out_res.address;
  assign rsp.fault_cause = out_res.cause;
  assign rsp.fault_entry = out_res.entry;

`ifndef SYNTHESIS
  // an idle walker always sits at level 1
  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    !st.active |-> st.level)
    else $error("idle walker not at level 1");

  // a finished or faulted walk leaves the walker idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && has_result && (res.kind == RK_DONE || res.kind == RK_FAULT))
      |=> !st.active)
    else $error("walk still active after done or fault");

  // faults carry a cause and a zero address; no other result carries both
  a_fault_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.result_kind == RK_FAULT) ==
                   (rsp.fault_cause != FC_NONE && rsp.address == '0)))
    else $error("fault fields inconsistent with result kind");

  // an entry word with no walk active never produces a result
  a_idle_entry: assert property (@(posedge clk) disable iff (rst)
    (adv && !st.active && in_item.operation == OP_ENTRY) |-> !has_result)
    else $error("result produced for entry while idle");
`endif

endmodule

`default_nettype wire
